@@ design/ttbs_pkg.sv @@
// ----------------------------------------------------------------------------
// ttbs_pkg: shared types and codes of the tick timer bank scheduler
// Word layouts, command and result codes, cell control and status bundles.
// ----------------------------------------------------------------------------
package ttbs_pkg;

   localparam int NUM_TIMERS_DEF   = 16;
   localparam int NUM_DEFERRED_DEF = 8;
   localparam int PERIOD_BITS_DEF  = 24;

   // command codes
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_ARM    = 3'd1;
   localparam logic [2:0] CMD_DISARM = 3'd2;
   localparam logic [2:0] CMD_ADD    = 3'd3;
   localparam logic [2:0] CMD_START  = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_ACCEPT = 3'd0;
   localparam logic [2:0] KIND_REJECT = 3'd1;
   localparam logic [2:0] KIND_TFIRE  = 3'd2;
   localparam logic [2:0] KIND_DFIRE  = 3'd3;
   localparam logic [2:0] KIND_IDLE   = 3'd4;

   typedef struct packed {
      logic [2:0]  command;
      logic [3:0]  timer_id;
      logic [23:0] period_ticks;
      logic        one_shot;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] fired_id;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_END
   } state_type;

   typedef struct packed {
      logic       step;
      logic       arm;
      logic       disarm;
      logic       one_shot;
      logic [3:0] timer_id;
   } tcell_ctl_type;

   typedef struct packed {
      logic step;
      logic add;
   } dcell_ctl_type;

   typedef struct packed {
      logic tok;
      logic busy;
      logic fire;
   } cell_stat_type;

endpackage

@@ design/ttbs_timer_cell.sv @@
// ----------------------------------------------------------------------------
// ttbs_timer_cell: one timer of the bank
// Holds armed flag, mode, reload and countdown; counts down when the scan
// token passes through it and hands the token to the next cell.
// ----------------------------------------------------------------------------
module ttbs_timer_cell #(
   parameter int INDEX       = 0,
   parameter int PERIOD_BITS = ttbs_pkg::PERIOD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ttbs_pkg::tcell_ctl_type ctl,
   input  logic [PERIOD_BITS-1:0]  period,
   input  logic                    token_prev,
   output ttbs_pkg::cell_stat_type stat
);
   import ttbs_pkg::*;

   logic                   armed_ff, armed_in;
   logic                   single_ff, single_in;
   logic                   tok_ff, tok_in;
   logic [PERIOD_BITS-1:0] reload_ff, reload_in;
   logic [PERIOD_BITS-1:0] left_ff, left_in;
   logic                   sel, hit, due;

   assign sel = (32'(ctl.timer_id) == INDEX);
   assign hit = tok_ff && ctl.step && armed_ff;
   assign due = (left_ff == PERIOD_BITS'(1));

   always_comb begin
      armed_in  = armed_ff;
      single_in = single_ff;
      reload_in = reload_ff;
      left_in   = left_ff;
      tok_in    = ctl.step ? token_prev : tok_ff;
      if (sel && ctl.arm) begin
         armed_in  = 1'b1;
         single_in = ctl.one_shot;
         reload_in = period;
         left_in   = period;
      end else if (sel && ctl.disarm) begin
         armed_in = 1'b0;
      end else if (hit) begin
         if (due) begin
            if (single_ff) begin
               armed_in = 1'b0;
            end else begin
               left_in = reload_ff;
            end
         end else begin
            left_in = left_ff - PERIOD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= 1'b0;
         single_ff <= 1'b0;
         tok_ff    <= 1'b0;
      end else begin
         armed_ff  <= armed_in;
         single_ff <= single_in;
         tok_ff    <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      reload_ff <= reload_in;
      left_ff   <= left_in;
   end

   assign stat.tok  = tok_ff;
   assign stat.busy = armed_ff;
   assign stat.fire = hit && due;

endmodule

@@ design/ttbs_defer_cell.sv @@
// ----------------------------------------------------------------------------
// ttbs_defer_cell: one slot of the deferred pool
// Counts down one delay while busy; takes part in the lowest-free-slot chain
// and in the scan token chain.
// ----------------------------------------------------------------------------
module ttbs_defer_cell #(
   parameter int PERIOD_BITS = ttbs_pkg::PERIOD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ttbs_pkg::dcell_ctl_type ctl,
   input  logic [PERIOD_BITS-1:0]  period,
   input  logic                    token_prev,
   input  logic                    open_prev,
   output logic                    open_next,
   output logic                    grant,
   output ttbs_pkg::cell_stat_type stat
);
   import ttbs_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   tok_ff, tok_in;
   logic [PERIOD_BITS-1:0] left_ff, left_in;
   logic                   hit, due;

   // search stays open past a busy slot, stops at the first free one
   assign open_next = open_prev && busy_ff;
   assign grant     = ctl.add && open_prev && !busy_ff;
   assign hit       = tok_ff && ctl.step && busy_ff;
   assign due       = (left_ff == PERIOD_BITS'(1));

   always_comb begin
      busy_in = busy_ff;
      left_in = left_ff;
      tok_in  = ctl.step ? token_prev : tok_ff;
      if (grant) begin
         busy_in = 1'b1;
         left_in = (period == '0) ? PERIOD_BITS'(1) : period;
      end else if (hit) begin
         if (due) begin
            busy_in = 1'b0;
         end else begin
            left_in = left_ff - PERIOD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         tok_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         tok_ff  <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
   end

   assign stat.tok  = tok_ff;
   assign stat.busy = busy_ff;
   assign stat.fire = hit && due;

endmodule

@@ design/tick_timer_bank_scheduler.sv @@
// ----------------------------------------------------------------------------
// tick_timer_bank_scheduler: bank of tick timers with a deferred pool
//
//   channel   dir   handshake              word
//   req_      in    req_valid/req_ready    req_payload (command, id, period)
//   rsp_      out   rsp_valid/rsp_ready    rsp_payload (kind, fired_id, last)
//
// Arm, disarm, add and start are captured, then executed.
// In a running tick a token walks the chain of cells one cell per cycle
// while rsp_ does not stall, timers first, then deferred slots.
// One fire is held back so the final word can carry last.
// Reset is synchronous and clears all flags; counts are written before use.
// A stalled rsp_ side freezes the token walk; the output register lets the
// next word be accepted while a result still waits.
// ----------------------------------------------------------------------------
module tick_timer_bank_scheduler #(
   parameter int NUM_TIMERS   = ttbs_pkg::NUM_TIMERS_DEF,
   parameter int NUM_DEFERRED = ttbs_pkg::NUM_DEFERRED_DEF,
   parameter int PERIOD_BITS  = ttbs_pkg::PERIOD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ttbs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttbs_pkg::rsp_type rsp_payload
);
   import ttbs_pkg::*;

   localparam int NUM_CELLS = NUM_TIMERS + NUM_DEFERRED;

   state_type              state_ff, state_in;
   req_type                req_ff;
   logic                   running_ff, running_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   pend_valid_ff, pend_valid_in;
   rsp_type                pend_ff, pend_in;

   logic                   adv, exec, id_ok, arm_ok, disarm_ok, add_ok;
   logic [PERIOD_BITS-1:0] per;
   tcell_ctl_type          tctl;
   dcell_ctl_type          dctl;
   cell_stat_type          t_stat [NUM_TIMERS];
   cell_stat_type          d_stat [NUM_DEFERRED];
   logic [NUM_DEFERRED:0]  open_chain;
   logic [NUM_DEFERRED-1:0] d_grant;
   logic [NUM_CELLS-1:0]   tok_vec;
   logic                   sel_armed, t_fire_any, d_fire_any;
   logic [3:0]             t_fire_id, d_fire_id, grant_id;
   logic                   out_load;
   rsp_type                out_word;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign exec      = (state_ff == ST_EXEC) && adv;
   assign per       = PERIOD_BITS'(req_ff.period_ticks);
   assign id_ok     = (32'(req_ff.timer_id) < NUM_TIMERS);
   assign arm_ok    = id_ok && (per != '0);
   assign disarm_ok = id_ok && sel_armed;
   assign add_ok    = running_ff && !open_chain[NUM_DEFERRED];

   assign tctl.step     = adv;
   assign tctl.arm      = exec && (req_ff.command == CMD_ARM) && arm_ok;
   assign tctl.disarm   = exec && (req_ff.command == CMD_DISARM) && disarm_ok;
   assign tctl.one_shot = req_ff.one_shot;
   assign tctl.timer_id = req_ff.timer_id;
   assign dctl.step     = adv;
   assign dctl.add      = exec && (req_ff.command == CMD_ADD) && running_ff;
   assign open_chain[0] = 1'b1;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
      logic tok_prev;
      if (i == 0) begin : g_head
         assign tok_prev = exec && (req_ff.command == CMD_TICK) && running_ff;
      end else begin : g_link
         assign tok_prev = t_stat[i-1].tok;
      end
      ttbs_timer_cell #(
         .INDEX       (i),
         .PERIOD_BITS (PERIOD_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (tctl),
         .period     (per),
         .token_prev (tok_prev),
         .stat       (t_stat[i])
      );
   end

   for (genvar i = 0; i < NUM_DEFERRED; i++) begin : g_defer
      logic tok_prev;
      if (i == 0) begin : g_head
         assign tok_prev = t_stat[NUM_TIMERS-1].tok;
      end else begin : g_link
         assign tok_prev = d_stat[i-1].tok;
      end
      ttbs_defer_cell #(
         .PERIOD_BITS (PERIOD_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (dctl),
         .period     (per),
         .token_prev (tok_prev),
         .open_prev  (open_chain[i]),
         .open_next  (open_chain[i+1]),
         .grant      (d_grant[i]),
         .stat       (d_stat[i])
      );
   end

   // fire flags are one-hot (single token), so ids merge by OR
   always_comb begin
      sel_armed  = 1'b0;
      t_fire_any = 1'b0;
      t_fire_id  = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         sel_armed  = sel_armed | (t_stat[i].busy && (32'(req_ff.timer_id) == i));
         t_fire_any = t_fire_any | t_stat[i].fire;
         t_fire_id  = t_fire_id | (t_stat[i].fire ? 4'(i) : 4'd0);
         tok_vec[i] = t_stat[i].tok;
      end
      d_fire_any = 1'b0;
      d_fire_id  = '0;
      grant_id   = '0;
      for (int i = 0; i < NUM_DEFERRED; i++) begin
         d_fire_any = d_fire_any | d_stat[i].fire;
         d_fire_id  = d_fire_id | (d_stat[i].fire ? 4'(i) : 4'd0);
         grant_id   = grant_id | (d_grant[i] ? 4'(i) : 4'd0);
         tok_vec[NUM_TIMERS+i] = d_stat[i].tok;
      end
   end

   always_comb begin
      state_in      = state_ff;
      running_in    = running_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_load      = 1'b0;
      out_word      = '{kind: KIND_REJECT, fired_id: 4'd0, last: 1'b1};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (adv) begin
               state_in = ST_IDLE;
               out_load = 1'b1;
               unique case (req_ff.command)
                  CMD_TICK: begin
                     if (running_ff) begin
                        state_in      = ST_SCAN;
                        out_load      = 1'b0;
                        pend_valid_in = 1'b0;
                     end else begin
                        out_word.kind = KIND_IDLE;
                     end
                  end
                  CMD_ARM: begin
                     out_word.kind = arm_ok ? KIND_ACCEPT : KIND_REJECT;
                  end
                  CMD_DISARM: begin
                     out_word.kind = disarm_ok ? KIND_ACCEPT : KIND_REJECT;
                  end
                  CMD_ADD: begin
                     if (add_ok) begin
                        out_word.kind     = KIND_ACCEPT;
                        out_word.fired_id = grant_id;
                     end
                  end
                  CMD_START: begin
                     running_in    = 1'b1;
                     out_word.kind = KIND_ACCEPT;
                  end
                  default: begin
                     out_word.kind = KIND_REJECT;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (adv) begin
               if (t_fire_any || d_fire_any) begin
                  // push the held fire out, hold the new one
                  out_load      = pend_valid_ff;
                  out_word      = pend_ff;
                  out_word.last = 1'b0;
                  pend_valid_in = 1'b1;
                  pend_in.kind     = t_fire_any ? KIND_TFIRE : KIND_DFIRE;
                  pend_in.fired_id = t_fire_any ? t_fire_id : d_fire_id;
                  pend_in.last     = 1'b0;
               end
               if (d_stat[NUM_DEFERRED-1].tok) begin
                  state_in = ST_END;
               end
            end
         end
         ST_END: begin
            if (adv) begin
               out_load      = 1'b1;
               state_in      = ST_IDLE;
               pend_valid_in = 1'b0;
               if (pend_valid_ff) begin
                  out_word = pend_ff;
               end else begin
                  out_word.kind = KIND_IDLE;
               end
               out_word.last = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = out_load ? out_word : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         running_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         running_ff    <= running_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one scan token in the chain");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_END) |-> (tok_vec == '0))
      else $error("scan token outside a tick scan");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_END))
      else $error("held fire outside a tick scan");

   a_running_sticks: assert property (@(posedge clock) disable iff (reset)
      running_ff |=> running_ff)
      else $error("run flag cleared without reset");

   a_fire_needs_token: assert property (@(posedge clock) disable iff (reset)
      (t_fire_any || d_fire_any) |-> (state_ff == ST_SCAN))
      else $error("fire outside a tick scan");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tick timer bank scheduler
// A short table of commands walks reset behavior, rejects, extremes and the
// first fires. A random mix of arms, disarms, deferred adds and tick runs
// follows. Every result word is matched against a fixed expected word or
// an in-bench bank model, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import ttbs_pkg::*;

   localparam int NT           = NUM_TIMERS_DEF;
   localparam int ND           = NUM_DEFERRED_DEF;
   localparam int RANDOM_WORDS = 195;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;

   // command codes the block does not implement
   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type result;
   } probe_row_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   int send_gap_pct   = 32;
   int recv_stall_pct = 86;
   int error_count    = 0;
   int words_sent     = 0;
   int results_seen   = 0;
   int timer_fires    = 0;
   int slot_fires     = 0;
   int idle_cycles    = 0;

   rsp_type       due_results[$];
   rsp_type       predicted[$];
   probe_row_type directed_rows[$];

   // bank model state
   logic        bank_running;
   logic        tmr_armed  [NT];
   logic        tmr_single [NT];
   logic [23:0] tmr_reload [NT];
   logic [23:0] tmr_left   [NT];
   logic        slot_busy  [ND];
   logic [23:0] slot_left  [ND];

   tick_timer_bank_scheduler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // fills predicted[] with the results one command word causes
   task automatic bank_predict(input req_type w);
      rsp_type r;
      bit      placed;
      int      i;
      r = '0;
      placed = 1'b0;
      predicted = {};
      case (w.command)
         CMD_TICK: begin
            if (bank_running) begin
               for (i = 0; i < NT; i++) begin
                  if (tmr_armed[i]) begin
                     tmr_left[i] = tmr_left[i] - 24'd1;
                     if (tmr_left[i] == '0) begin
                        r.kind = KIND_TFIRE;
                        r.fired_id = i[3:0];
                        predicted.push_back(r);
                        if (tmr_single[i]) tmr_armed[i] = 1'b0;
                        else tmr_left[i] = tmr_reload[i];
                     end
                  end
               end
               for (i = 0; i < ND; i++) begin
                  if (slot_busy[i]) begin
                     slot_left[i] = slot_left[i] - 24'd1;
                     if (slot_left[i] == '0) begin
                        r.kind = KIND_DFIRE;
                        r.fired_id = i[3:0];
                        predicted.push_back(r);
                        slot_busy[i] = 1'b0;
                     end
                  end
               end
            end
            if (predicted.size() == 0) begin
               r.kind = KIND_IDLE;
               r.fired_id = '0;
               predicted.push_back(r);
            end
         end
         CMD_ARM: begin
            if (w.period_ticks == '0) begin
               r.kind = KIND_REJECT;
            end else begin
               tmr_armed[w.timer_id]  = 1'b1;
               tmr_single[w.timer_id] = w.one_shot;
               tmr_reload[w.timer_id] = w.period_ticks;
               tmr_left[w.timer_id]   = w.period_ticks;
               r.kind = KIND_ACCEPT;
            end
            predicted.push_back(r);
         end
         CMD_DISARM: begin
            if (!tmr_armed[w.timer_id]) begin
               r.kind = KIND_REJECT;
            end else begin
               tmr_armed[w.timer_id] = 1'b0;
               r.kind = KIND_ACCEPT;
            end
            predicted.push_back(r);
         end
         CMD_ADD: begin
            r.kind = KIND_REJECT;
            if (bank_running) begin
               for (i = 0; i < ND && !placed; i++) begin
                  if (!slot_busy[i]) begin
                     slot_busy[i] = 1'b1;
                     slot_left[i] = (w.period_ticks == '0) ? 24'd1 : w.period_ticks;
                     r.kind = KIND_ACCEPT;
                     r.fired_id = i[3:0];
                     placed = 1'b1;
                  end
               end
            end
            predicted.push_back(r);
         end
         CMD_START: begin
            bank_running = 1'b1;
            r.kind = KIND_ACCEPT;
            predicted.push_back(r);
         end
         default: begin
            r.kind = KIND_REJECT;
            predicted.push_back(r);
         end
      endcase
      r = predicted.pop_back();
      r.last = 1'b1;
      predicted.push_back(r);
   endtask

   function automatic req_type make_word(input logic [2:0] cmd, input logic [3:0] id,
                                         input logic [23:0] per, input logic shot);
      req_type w;
      w.command = cmd;
      w.timer_id = id;
      w.period_ticks = per;
      w.one_shot = shot;
      return w;
   endfunction

   function automatic probe_row_type probe(input logic [2:0] cmd, input logic [3:0] id,
                                           input logic [23:0] per, input logic shot,
                                           input bit typed, input logic [2:0] kind,
                                           input logic [3:0] fid);
      probe_row_type p;
      p.word = make_word(cmd, id, per, shot);
      p.typed = typed;
      p.result.kind = kind;
      p.result.fired_id = fid;
      p.result.last = 1'b1;
      return p;
   endfunction

   // deferred delays stay short so the pool keeps turning over
   function automatic logic [23:0] random_period(input bit short_only);
      int pick;
      int base;
      pick = $urandom_range(0, 15);
      base = 1 << $urandom_range(0, 6);
      if (pick == 0) return '0;
      if (pick <= 2 && !short_only) return 24'($urandom());
      if (pick <= 5) return 24'(base - 1 + $urandom_range(0, 2));
      return 24'($urandom_range(1, short_only ? 40 : 24));
   endfunction

   function automatic req_type random_word();
      req_type w;
      int      pick;
      pick = $urandom_range(0, 99);
      w.timer_id = 4'($urandom_range(0, 15));
      w.one_shot = 1'($urandom_range(0, 1));
      if (pick < 42) w.command = CMD_TICK;
      else if (pick < 65) w.command = CMD_ARM;
      else if (pick < 78) w.command = CMD_DISARM;
      else if (pick < 92) w.command = CMD_ADD;
      else if (pick < 95) w.command = CMD_START;
      else w.command = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      w.period_ticks = random_period(w.command == CMD_ADD);
      return w;
   endfunction

   // called at a rising edge; returns at the edge where the word is taken
   task automatic send_word(input req_type w, input bit typed, input rsp_type fixed);
      if ($urandom_range(99, 0) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99, 0) < send_gap_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      bank_predict(w);
      if (typed) due_results.push_back(fixed);
      else foreach (predicted[k]) due_results.push_back(predicted[k]);
   endtask

   task automatic hold_off();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (got.kind == KIND_TFIRE) timer_fires++;
      if (got.kind == KIND_DFIRE) slot_fires++;
      if (due_results.size() == 0) begin
         $error("result word with nothing outstanding: kind %0d id %0d last %0d",
                got.kind, got.fired_id, got.last);
         error_count++;
      end else begin
         want = due_results.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            error_count++;
         end
         if (got.fired_id !== want.fired_id) begin
            $error("fired_id: expected %0d, got %0d", want.fired_id, got.fired_id);
            error_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_payload);
         rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      int      sent;
      int      pick;
      int      phase_now;
      int      phase_seen;
      int      k;
      req_type w;

      bank_running = 1'b0;
      for (k = 0; k < NT; k++) begin
         tmr_armed[k] = 1'b0;
         tmr_single[k] = 1'b0;
         tmr_reload[k] = '0;
         tmr_left[k] = '0;
      end
      for (k = 0; k < ND; k++) begin
         slot_busy[k] = 1'b0;
         slot_left[k] = '0;
      end

      // stopped bank, rejects, extremes, then the first fires
      directed_rows.push_back(probe(CMD_TICK,   4'd0,  24'd0,      1'b0, 1, KIND_IDLE,   4'd0));
      directed_rows.push_back(probe(CMD_ARM,    4'd4,  24'd0,      1'b0, 1, KIND_REJECT, 4'd0));
      directed_rows.push_back(probe(CMD_DISARM, 4'd9,  24'd20,     1'b0, 1, KIND_REJECT, 4'd0));
      directed_rows.push_back(probe(CMD_ADD,    4'd0,  24'd5,      1'b0, 1, KIND_REJECT, 4'd0));
      directed_rows.push_back(probe(CMD_UNUSED_FIRST, 4'd3, 24'd9, 1'b1, 1, KIND_REJECT, 4'd0));
      directed_rows.push_back(probe(CMD_UNUSED_LAST,  4'd0, 24'd1, 1'b0, 1, KIND_REJECT, 4'd0));
      directed_rows.push_back(probe(CMD_ARM,    4'd0,  24'd1,      1'b0, 1, KIND_ACCEPT, 4'd0));
      directed_rows.push_back(probe(CMD_ARM,    4'd15, 24'd2,      1'b1, 1, KIND_ACCEPT, 4'd0));
      directed_rows.push_back(probe(CMD_ARM,    4'd7,  24'hFFFFFF, 1'b0, 1, KIND_ACCEPT, 4'd0));
      directed_rows.push_back(probe(CMD_TICK,   4'd0,  24'd0,      1'b0, 1, KIND_IDLE,   4'd0));
      directed_rows.push_back(probe(CMD_START,  4'd0,  24'd0,      1'b0, 1, KIND_ACCEPT, 4'd0));
      directed_rows.push_back(probe(CMD_START,  4'd15, 24'hFFFFFF, 1'b1, 1, KIND_ACCEPT, 4'd0));
      directed_rows.push_back(probe(CMD_ADD,    4'd0,  24'd0,      1'b0, 1, KIND_ACCEPT, 4'd0));
      directed_rows.push_back(probe(CMD_ADD,    4'd0,  24'd3,      1'b0, 1, KIND_ACCEPT, 4'd1));
      directed_rows.push_back(probe(CMD_TICK,   4'd0,  24'd0,      1'b0, 0, KIND_IDLE,   4'd0));
      directed_rows.push_back(probe(CMD_TICK,   4'd0,  24'd0,      1'b0, 0, KIND_IDLE,   4'd0));
      directed_rows.push_back(probe(CMD_TICK,   4'd0,  24'd0,      1'b0, 0, KIND_IDLE,   4'd0));
      // one-shot timer re-armed after it fired
      directed_rows.push_back(probe(CMD_ARM,    4'd15, 24'd1,      1'b1, 1, KIND_ACCEPT, 4'd0));
      directed_rows.push_back(probe(CMD_TICK,   4'd0,  24'd0,      1'b0, 0, KIND_IDLE,   4'd0));
      directed_rows.push_back(probe(CMD_DISARM, 4'd0,  24'd0,      1'b0, 1, KIND_ACCEPT, 4'd0));
      directed_rows.push_back(probe(CMD_DISARM, 4'd0,  24'd0,      1'b0, 1, KIND_REJECT, 4'd0));
      directed_rows.push_back(probe(CMD_ARM,    4'd3,  24'd256,    1'b0, 1, KIND_ACCEPT, 4'd0));
      directed_rows.push_back(probe(CMD_ARM,    4'd7,  24'd4,      1'b0, 1, KIND_ACCEPT, 4'd0));
      directed_rows.push_back(probe(CMD_DISARM, 4'd3,  24'd0,      1'b0, 1, KIND_ACCEPT, 4'd0));
      directed_rows.push_back(probe(CMD_TICK,   4'd0,  24'd0,      1'b0, 0, KIND_IDLE,   4'd0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].result);
      end
      hold_off();

      sent = 0;
      phase_seen = 0;
      while (sent < RANDOM_WORDS) begin
         phase_now = (sent * 3) / RANDOM_WORDS;
         if (phase_now != phase_seen) begin
            phase_seen = phase_now;
            hold_off();
            send_gap_pct   = (phase_now == 1) ? 86 : 0;
            recv_stall_pct = (phase_now == 1) ? 32 : 0;
         end
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            // fill the deferred pool and try one more
            for (k = 0; k <= ND; k++) begin
               w = make_word(CMD_ADD, 4'($urandom_range(0, 15)),
                             24'($urandom_range(1, 40)), 1'($urandom_range(0, 1)));
               send_word(w, 0, '0);
               sent++;
            end
         end else if (pick <= 2) begin
            // a few short timers, then a run of ticks to let them fire
            for (k = 0; k < 3; k++) begin
               w = make_word(CMD_ARM, 4'($urandom_range(0, 15)),
                             24'($urandom_range(1, 12)), 1'($urandom_range(0, 1)));
               send_word(w, 0, '0);
               sent++;
            end
            for (k = 0; k < 8; k++) begin
               send_word(make_word(CMD_TICK, 4'($urandom_range(0, 15)), '0, 1'b0), 0, '0);
               sent++;
            end
         end else begin
            send_word(random_word(), 0, '0);
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d command words in, %0d result words checked",
               words_sent, results_seen);
      $display("summary: %0d timer fires, %0d deferred fires, under three idling mixes",
               timer_fires, slot_fires);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/ttbs_pkg.sv
design/ttbs_timer_cell.sv
design/ttbs_defer_cell.sv
design/tick_timer_bank_scheduler.sv
sim/testbench.sv
